// File: src/grouped_free_block_stack_assert.svh
// ----------------------------------------------------------------------------
// grouped_free_block_stack_assert.svh
// Assertion macros used by gfbs_checker, the port-level checker of the free block stack.
// ----------------------------------------------------------------------------
`ifndef GROUPED_FREE_BLOCK_STACK_ASSERT_SVH
`define GROUPED_FREE_BLOCK_STACK_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet in reset.
`define GFBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet in reset.
`define GFBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/gfbs_pkg.sv
// ----------------------------------------------------------------------------
// gfbs_pkg
// Types, codes and fixed widths of the grouped free block stack.
// ----------------------------------------------------------------------------
package gfbs_pkg;

    localparam int CMD_W  = 2;
    localparam int WORD_W = 32;
    localparam int KIND_W = 3;
    localparam int STAT_W = 2;
    localparam int OFF_W  = 6;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FILL  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SPILL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FILL  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_READREQ,
        S_SPILL
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SKIP,
        OP_ALLOC_REFUSE,
        OP_ALLOC_EMPTY,
        OP_POP,
        OP_FREE_REFUSE,
        OP_PUSH,
        OP_SPILL_START,
        OP_FILL_STRAY,
        OP_FILL_HDR,
        OP_FILL_ENTRY,
        OP_EMIT_ALLOC,
        OP_EMIT_READREQ,
        OP_EMIT_SPILL
    } op_t;

    typedef struct packed {
        logic filling;
        logic header_pending;
        logic cnt_zero;
        logic cnt_full;
        logic slot_free;
        logic spill_end;
    } dp_status_t;

endpackage

// File: src/gfbs_ram.sv
// ----------------------------------------------------------------------------
// gfbs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gfbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/gfbs_ctrl.sv
// ----------------------------------------------------------------------------
// gfbs_ctrl
// Sequencer: decodes commands and paces the multi-beat replies.
// ----------------------------------------------------------------------------
module gfbs_ctrl
    import gfbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  logic [CMD_W-1:0] command,
    input  dp_status_t       dp_status,
    output op_t              op
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && dp_status.slot_free)
                begin
                    if (command == CMD_ALLOC && !dp_status.filling && !dp_status.cnt_zero)
                    begin
                        state_next = S_POP;
                    end
                    else if (command == CMD_FREE && !dp_status.filling
                             && dp_status.cnt_full)
                    begin
                        state_next = S_SPILL;
                    end
                end
            end
            S_POP:
            begin
                if (dp_status.slot_free)
                begin
                    state_next = dp_status.filling ? S_READREQ : S_IDLE;
                end
            end
            S_READREQ:
            begin
                if (dp_status.slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SPILL:
            begin
                if (dp_status.slot_free && dp_status.spill_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_ready = 1'b0;
        op        = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = dp_status.slot_free;
                if (cmd_valid && dp_status.slot_free)
                begin
                    case (command)
                        CMD_ALLOC:
                        begin
                            if (dp_status.filling)
                            begin
                                op = OP_ALLOC_REFUSE;
                            end
                            else if (dp_status.cnt_zero)
                            begin
                                op = OP_ALLOC_EMPTY;
                            end
                            else
                            begin
                                op = OP_POP;
                            end
                        end
                        CMD_FREE:
                        begin
                            if (dp_status.filling)
                            begin
                                op = OP_FREE_REFUSE;
                            end
                            else if (dp_status.cnt_full)
                            begin
                                op = OP_SPILL_START;
                            end
                            else
                            begin
                                op = OP_PUSH;
                            end
                        end
                        CMD_FILL:
                        begin
                            if (!dp_status.filling)
                            begin
                                op = OP_FILL_STRAY;
                            end
                            else if (dp_status.header_pending)
                            begin
                                op = OP_FILL_HDR;
                            end
                            else
                            begin
                                op = OP_FILL_ENTRY;
                            end
                        end
                        default:
                        begin
                            op = OP_SKIP;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                if (dp_status.slot_free)
                begin
                    op = OP_EMIT_ALLOC;
                end
            end
            S_READREQ:
            begin
                if (dp_status.slot_free)
                begin
                    op = OP_EMIT_READREQ;
                end
            end
            S_SPILL:
            begin
                if (dp_status.slot_free)
                begin
                    op = OP_EMIT_SPILL;
                end
            end
            default:
            begin
                op = OP_NONE;
            end
        endcase
    end

endmodule

// File: src/gfbs_dp.sv
// ----------------------------------------------------------------------------
// gfbs_dp
// Datapath: stack memory, count and fill state, spill walker, reply register.
// ----------------------------------------------------------------------------
module gfbs_dp
    import gfbs_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  op_t               op,
    input  logic [WORD_W-1:0] block_number,
    input  logic [WORD_W-1:0] fill_word,
    output dp_status_t        dp_status,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic [KIND_W-1:0] kind,
    output logic [STAT_W-1:0] status,
    output logic [WORD_W-1:0] block_out,
    output logic [OFF_W-1:0]  word_offset,
    output logic [WORD_W-1:0] data_word,
    output logic [OFF_W-1:0]  count_after,
    output logic              dirty,
    output logic              last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    logic [CNT_W-1:0]  count_reg,  count_next;
    logic              filling_reg, filling_next;
    logic              hdr_reg,    hdr_next;
    logic [CNT_W-1:0]  expect_reg, expect_next;
    logic [CNT_W-1:0]  index_reg,  index_next;
    logic              dirty_reg,  dirty_next;
    logic [WORD_W-1:0] blk_reg,    blk_next;
    logic [IDX_W-1:0]  spill_reg,  spill_next;

    logic              rsp_valid_reg, rsp_valid_next;
    logic [KIND_W-1:0] kind_reg,  kind_next;
    logic [STAT_W-1:0] stat_reg,  stat_next;
    logic [WORD_W-1:0] bout_reg,  bout_next;
    logic [OFF_W-1:0]  off_reg,   off_next;
    logic [WORD_W-1:0] data_reg,  data_next;
    logic [OFF_W-1:0]  cnt_o_reg, cnt_o_next;
    logic              dirty_o_reg, dirty_o_next;
    logic              last_reg,  last_next;

    logic              load;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
    logic [WORD_W-1:0] rdata;
    logic [CNT_W-1:0]  cnt_dec;
    logic [CNT_W-1:0]  index_inc;
    logic              spill_end;
    logic              hdr_bad;

    gfbs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_stack (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign cnt_dec   = count_reg - CNT_W'(1);
    assign index_inc = index_reg + CNT_W'(1);
    assign spill_end = (spill_reg == IDX_W'(CAPACITY - 1));
    assign hdr_bad   = (fill_word == '0) || (fill_word > WORD_W'(CAPACITY));

    assign dp_status.filling        = filling_reg;
    assign dp_status.header_pending = hdr_reg;
    assign dp_status.cnt_zero       = (count_reg == '0);
    assign dp_status.cnt_full       = (count_reg >= CNT_W'(CAPACITY));
    assign dp_status.slot_free      = !rsp_valid_reg || rsp_ready;
    assign dp_status.spill_end      = spill_end;

    always_comb
    begin
        count_next   = count_reg;
        filling_next = filling_reg;
        hdr_next     = hdr_reg;
        expect_next  = expect_reg;
        index_next   = index_reg;
        dirty_next   = dirty_reg;
        blk_next     = blk_reg;
        spill_next   = spill_reg;
        we           = 1'b0;
        waddr        = count_reg[IDX_W-1:0];
        wdata        = block_number;
        re           = 1'b0;
        raddr        = cnt_dec[IDX_W-1:0];
        load         = 1'b1;
        kind_next    = KIND_ALLOC;
        stat_next    = STAT_OK;
        bout_next    = '0;
        off_next     = '0;
        data_next    = '0;
        last_next    = 1'b1;
        case (op)
            OP_ALLOC_REFUSE:
            begin
                stat_next = STAT_REFUSED;
            end
            OP_ALLOC_EMPTY:
            begin
                stat_next = STAT_NOSPACE;
            end
            OP_POP:
            begin
                load       = 1'b0;
                re         = 1'b1;
                dirty_next = 1'b1;
                if (count_reg == CNT_W'(1))
                begin
                    count_next   = '0;
                    filling_next = 1'b1;
                    hdr_next     = 1'b1;
                    expect_next  = '0;
                    index_next   = '0;
                end
                else
                begin
                    count_next = cnt_dec;
                end
            end
            OP_EMIT_ALLOC:
            begin
                bout_next = rdata;
                last_next = !filling_reg;
            end
            OP_EMIT_READREQ:
            begin
                kind_next = KIND_READ;
                bout_next = rdata;
            end
            OP_FREE_REFUSE:
            begin
                kind_next = KIND_FREE;
                stat_next = STAT_REFUSED;
            end
            OP_PUSH:
            begin
                we         = 1'b1;
                count_next = count_reg + CNT_W'(1);
                dirty_next = 1'b1;
                kind_next  = KIND_FREE;
            end
            OP_SPILL_START:
            begin
                blk_next   = block_number;
                count_next = CNT_W'(1);
                dirty_next = 1'b1;
                spill_next = '0;
                re         = 1'b1;
                raddr      = '0;
                kind_next  = KIND_SPILL;
                bout_next  = block_number;
                data_next  = WORD_W'(CAPACITY);
                last_next  = 1'b0;
            end
            OP_EMIT_SPILL:
            begin
                kind_next = KIND_SPILL;
                bout_next = blk_reg;
                off_next  = OFF_W'(spill_reg) + OFF_W'(1);
                data_next = rdata;
                last_next = spill_end;
                if (spill_end)
                begin
                    we    = 1'b1;
                    waddr = '0;
                    wdata = blk_reg;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = spill_reg + IDX_W'(1);
                    spill_next = spill_reg + IDX_W'(1);
                end
            end
            OP_FILL_STRAY:
            begin
                kind_next = KIND_FILL;
                stat_next = STAT_REFUSED;
            end
            OP_FILL_HDR:
            begin
                kind_next  = KIND_FILL;
                hdr_next   = 1'b0;
                index_next = '0;
                if (hdr_bad)
                begin
                    filling_next = 1'b0;
                    count_next   = '0;
                    expect_next  = '0;
                end
                else
                begin
                    expect_next = fill_word[CNT_W-1:0];
                end
            end
            OP_FILL_ENTRY:
            begin
                kind_next  = KIND_FILL;
                we         = 1'b1;
                waddr      = index_reg[IDX_W-1:0];
                wdata      = fill_word;
                index_next = index_inc;
                if (index_inc >= expect_reg)
                begin
                    count_next   = expect_reg;
                    filling_next = 1'b0;
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
        cnt_o_next     = OFF_W'(count_next);
        dirty_o_next   = dirty_next;
        rsp_valid_next = load ? 1'b1 : (rsp_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            filling_reg   <= 1'b0;
            hdr_reg       <= 1'b0;
            expect_reg    <= '0;
            index_reg     <= '0;
            dirty_reg     <= 1'b0;
            spill_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            filling_reg   <= filling_next;
            hdr_reg       <= hdr_next;
            expect_reg    <= expect_next;
            index_reg     <= index_next;
            dirty_reg     <= dirty_next;
            spill_reg     <= spill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        if (load)
        begin
            kind_reg    <= kind_next;
            stat_reg    <= stat_next;
            bout_reg    <= bout_next;
            off_reg     <= off_next;
            data_reg    <= data_next;
            cnt_o_reg   <= cnt_o_next;
            dirty_o_reg <= dirty_o_next;
            last_reg    <= last_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign kind        = kind_reg;
    assign status      = stat_reg;
    assign block_out   = bout_reg;
    assign word_offset = off_reg;
    assign data_word   = data_reg;
    assign count_after = cnt_o_reg;
    assign dirty       = dirty_o_reg;
    assign last        = last_reg;

endmodule

// File: src/grouped_free_block_stack.sv
// ----------------------------------------------------------------------------
// grouped_free_block_stack
// Grouped free block list: a stack of free block numbers that spills to and
// refills from group blocks.
//
//   channel | valid / ready         | payload
//   --------+-----------------------+------------------------------------------
//   cmd     | cmd_valid / cmd_ready | command, block_number, fill_word
//   rsp     | rsp_valid / rsp_ready | kind, status, block_out, word_offset,
//           |                       | data_word, count_after, dirty, last
//
// Free, fill words, refused and empty-stack commands: one reply beat each.
// Allocate: the stack memory read is registered and the reply beat is sent
// from S_POP; last-entry allocate adds a read request beat from S_READREQ.
// Free on a full stack: a header beat and one beat per stack entry, one spill
// beat per cycle while rsp_ready holds.
// A reply waiting in the output register stalls cmd_ready only when the
// register cannot drain. Reset is asynchronous and empties the stack at once.
// ----------------------------------------------------------------------------
module grouped_free_block_stack
    import gfbs_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  logic [CMD_W-1:0]  command,
    input  logic [WORD_W-1:0] block_number,
    input  logic [WORD_W-1:0] fill_word,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic [KIND_W-1:0] kind,
    output logic [STAT_W-1:0] status,
    output logic [WORD_W-1:0] block_out,
    output logic [OFF_W-1:0]  word_offset,
    output logic [WORD_W-1:0] data_word,
    output logic [OFF_W-1:0]  count_after,
    output logic              dirty,
    output logic              last
);

    op_t        op;
    dp_status_t dp_status;

    gfbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .command   (command),
        .dp_status (dp_status),
        .op        (op)
    );

    gfbs_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .block_number (block_number),
        .fill_word    (fill_word),
        .dp_status    (dp_status),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .kind         (kind),
        .status       (status),
        .block_out    (block_out),
        .word_offset  (word_offset),
        .data_word    (data_word),
        .count_after  (count_after),
        .dirty        (dirty),
        .last         (last)
    );

endmodule

// File: src/gfbs_checker.sv
// ----------------------------------------------------------------------------
// gfbs_checker
// Port-level checks of the free block stack, bound to the top level.
// ----------------------------------------------------------------------------
module gfbs_checker
    import gfbs_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [KIND_W-1:0] kind,
    input logic [WORD_W-1:0] block_out,
    input logic [OFF_W-1:0]  word_offset,
    input logic [OFF_W-1:0]  count_after,
    input logic              last
);

`include "grouped_free_block_stack_assert.svh"

    `GFBS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(kind) && $stable(block_out) && $stable(last), "rsp beat dropped or changed while stalled")

    `GFBS_ASSERT_NOW(a_count_cap, rsp_valid, count_after <= OFF_W'(CAPACITY), "count_after above capacity")

    `GFBS_ASSERT_NOW(a_busy_mid_burst, rsp_valid && !last, !cmd_ready, "command taken in the middle of a burst")

    `GFBS_ASSERT_NEXT(a_spill_next, rsp_valid && rsp_ready && kind == KIND_SPILL && !last, rsp_valid && kind == KIND_SPILL && word_offset == $past(word_offset) + OFF_W'(1), "spill beats not consecutive")

    `GFBS_ASSERT_NEXT(a_read_follows, rsp_valid && rsp_ready && kind == KIND_ALLOC && !last, rsp_valid && kind == KIND_READ && block_out == $past(block_out), "read request does not follow last allocate")

endmodule

bind grouped_free_block_stack gfbs_checker #(
    .CAPACITY (CAPACITY)
) u_gfbs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_ready   (cmd_ready),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .kind        (kind),
    .block_out   (block_out),
    .word_offset (word_offset),
    .count_after (count_after),
    .last        (last)
);

// File: tb/sv/gfbs_reply_checker.sv
// ----------------------------------------------------------------------------
// gfbs_reply_checker
// Watches the command and reply channels of the grouped free block stack,
// keeps its own copy of the stack, fill progress and dirty flag, works out the
// reply beats each accepted command must cause and compares every accepted
// reply beat, field by field, against the oldest one still awaited.
// ----------------------------------------------------------------------------
module gfbs_reply_checker
    import gfbs_pkg::*;
#(
    parameter int CAP = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_ready,
    input  logic [CMD_W-1:0]  command,
    input  logic [WORD_W-1:0] block_number,
    input  logic [WORD_W-1:0] fill_word,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  logic [KIND_W-1:0] kind,
    input  logic [STAT_W-1:0] status,
    input  logic [WORD_W-1:0] block_out,
    input  logic [OFF_W-1:0]  word_offset,
    input  logic [WORD_W-1:0] data_word,
    input  logic [OFF_W-1:0]  count_after,
    input  logic              dirty,
    input  logic              last,
    output int                errors,
    output int                outstanding,
    output int                beats_checked,
    output logic [OFF_W-1:0]  held,
    output logic              refilling,
    output logic              want_header
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] blk;
        logic [OFF_W-1:0]  off;
        logic [WORD_W-1:0] data;
        logic [OFF_W-1:0]  held;
        logic              dirty;
        logic              last;
    } reply_t;

    logic [WORD_W-1:0] stack_mem [CAP];
    logic [OFF_W-1:0]  fill_total;
    logic [OFF_W-1:0]  fill_pos;
    logic              touched;
    reply_t            awaited [$];
    reply_t            batch [$];

    initial
    begin
        errors        = 0;
        outstanding   = 0;
        beats_checked = 0;
    end

    task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        reply_t            r;
        reply_t            head;
        logic [WORD_W-1:0] got;
        if (!rst_n)
        begin
            foreach (stack_mem[i])
                stack_mem[i] = '0;
            held        = '0;
            refilling   = 1'b0;
            want_header = 1'b0;
            fill_total  = '0;
            fill_pos    = '0;
            touched     = 1'b0;
            awaited.delete();
            outstanding = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                beats_checked++;
                if (awaited.size() == 0)
                begin
                    $error("reply beat with nothing awaited: kind %0d status %0d",
                           kind, status);
                    errors++;
                end
                else
                begin
                    head = awaited.pop_front();
                    compare_field("kind", WORD_W'(head.kind), WORD_W'(kind));
                    compare_field("status", WORD_W'(head.status), WORD_W'(status));
                    compare_field("block_out", head.blk, block_out);
                    compare_field("word_offset", WORD_W'(head.off), WORD_W'(word_offset));
                    compare_field("data_word", head.data, data_word);
                    compare_field("count_after", WORD_W'(head.held), WORD_W'(count_after));
                    compare_field("dirty", WORD_W'(head.dirty), WORD_W'(dirty));
                    compare_field("last", WORD_W'(head.last), WORD_W'(last));
                end
            end

            if (cmd_valid && cmd_ready)
            begin
                batch.delete();
                r = '0;
                case (command)
                    CMD_ALLOC:
                    begin
                        r.kind = KIND_ALLOC;
                        if (refilling)
                        begin
                            r.status = STAT_REFUSED;
                            batch.push_back(r);
                        end
                        else if (held == 0)
                        begin
                            r.status = STAT_NOSPACE;
                            batch.push_back(r);
                        end
                        else
                        begin
                            got     = stack_mem[held - 1];
                            touched = 1'b1;
                            r.blk   = got;
                            batch.push_back(r);
                            if (held == 1)
                            begin
                                held        = '0;
                                refilling   = 1'b1;
                                want_header = 1'b1;
                                fill_total  = '0;
                                fill_pos    = '0;
                                r.kind      = KIND_READ;
                                batch.push_back(r);
                            end
                            else
                            begin
                                held--;
                            end
                        end
                    end
                    CMD_FREE:
                    begin
                        if (refilling)
                        begin
                            r.kind   = KIND_FREE;
                            r.status = STAT_REFUSED;
                            batch.push_back(r);
                        end
                        else if (held >= CAP)
                        begin
                            r.kind = KIND_SPILL;
                            r.blk  = block_number;
                            r.data = WORD_W'(CAP);
                            batch.push_back(r);
                            for (int i = 0; i < CAP; i++)
                            begin
                                r.off  = OFF_W'(i + 1);
                                r.data = stack_mem[i];
                                batch.push_back(r);
                            end
                            stack_mem[0] = block_number;
                            held         = OFF_W'(1);
                            touched      = 1'b1;
                        end
                        else
                        begin
                            stack_mem[held] = block_number;
                            held++;
                            touched = 1'b1;
                            r.kind  = KIND_FREE;
                            batch.push_back(r);
                        end
                    end
                    CMD_FILL:
                    begin
                        r.kind = KIND_FILL;
                        if (!refilling)
                        begin
                            r.status = STAT_REFUSED;
                        end
                        else if (want_header)
                        begin
                            want_header = 1'b0;
                            fill_pos    = '0;
                            if (fill_word == 0 || fill_word > CAP)
                            begin
                                refilling  = 1'b0;
                                held       = '0;
                                fill_total = '0;
                            end
                            else
                            begin
                                fill_total = fill_word[OFF_W-1:0];
                            end
                        end
                        else
                        begin
                            stack_mem[fill_pos] = fill_word;
                            fill_pos++;
                            if (fill_pos >= fill_total)
                            begin
                                held      = fill_total;
                                refilling = 1'b0;
                            end
                        end
                        batch.push_back(r);
                    end
                    default:
                    begin
                    end
                endcase
                foreach (batch[i])
                begin
                    batch[i].held  = held;
                    batch[i].dirty = touched;
                    batch[i].last  = (i == batch.size() - 1);
                    awaited.push_back(batch[i]);
                end
            end
            outstanding = awaited.size();
        end
    end

endmodule

// File: tb/sv/tb_grouped_free_block_stack.sv
// ----------------------------------------------------------------------------
// tb_grouped_free_block_stack
// Drives allocate, free and fill commands into the grouped free block stack
// with random gaps and random reply back-pressure. A short directed run hits
// the empty, last-entry, refused and bad-header cases; random traffic then
// grows the stack to full spills and drains it into group reads that are
// mostly answered with well-formed fills. Checking lives in gfbs_reply_checker and the bound gfbs_checker.
// ----------------------------------------------------------------------------
module tb_grouped_free_block_stack;
    import gfbs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int               CAP          = 32;
    localparam int               RANDOM_ITEMS = 420;
    localparam int               DRAIN_CYCLES = 80;
    localparam int               STALL_LIMIT  = 5000;
    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cmd_valid = 1'b0;
    logic              cmd_ready;
    logic [CMD_W-1:0]  command = CMD_ALLOC;
    logic [WORD_W-1:0] block_number = '0;
    logic [WORD_W-1:0] fill_word = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    logic [KIND_W-1:0] kind;
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] block_out;
    logic [OFF_W-1:0]  word_offset;
    logic [WORD_W-1:0] data_word;
    logic [OFF_W-1:0]  count_after;
    logic              dirty;
    logic              last;

    int               errors;
    int               outstanding;
    int               beats_checked;
    logic [OFF_W-1:0] held;
    logic             refilling;
    logic             want_header;

    int n_items = 0;
    int n_spills = 0;
    int n_reads = 0;
    int idle_cycles = 0;
    bit no_gaps = 1'b0;
    bit fast_drain = 1'b0;

    always #5 clk = ~clk;

    grouped_free_block_stack #(.CAPACITY(CAP)) dut (.*);

    gfbs_reply_checker #(.CAP(CAP)) stack_check (.*);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb_grouped_free_block_stack NOT OK");
                $finish;
            end
        end
    end

    // reply side: random stall per beat, with stretches of none
    initial
    begin : drain
        int stall;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                fast_drain = !fast_drain;
            stall = fast_drain ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            @(negedge clk);
        end
    end

    task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [WORD_W-1:0] blk,
                            input logic [WORD_W-1:0] word);
        int gap;
        if (op != CMD_UNUSED)
            n_items++;
        if (op == CMD_FREE && !refilling && held == CAP)
            n_spills++;
        if (op == CMD_ALLOC && !refilling && held == 1)
            n_reads++;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid    <= 1'b1;
        command      <= op;
        block_number <= blk;
        fill_word    <= word;
        do @(posedge clk); while (!cmd_ready);
        @(negedge clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_header();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(1, 4);
            3, 4, 5: return $urandom_range(1, CAP);
            6:       return CAP;
            7:       return 0;
            8:       return $urandom_range(CAP + 1, 63);
            default: return $urandom | 32'h40;
        endcase
    endfunction

    initial
    begin : stimulus
        int  target;
        int  r;
        bit  growing;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_cmd(CMD_ALLOC, '0, '0);
        send_cmd(CMD_FILL, '0, 32'h1234_5678);
        send_cmd(CMD_UNUSED, '1, '1);
        send_cmd(CMD_FREE, '1, '0);
        send_cmd(CMD_FREE, '0, '1);
        send_cmd(CMD_ALLOC, '0, '0);
        send_cmd(CMD_ALLOC, '0, '0);
        send_cmd(CMD_ALLOC, '0, '0);
        send_cmd(CMD_FREE, 32'hA5A5_5A5A, '0);
        send_cmd(CMD_FILL, '0, 32'd0);
        send_cmd(CMD_FREE, 32'd5, '0);
        send_cmd(CMD_ALLOC, '0, '0);
        send_cmd(CMD_FILL, '0, CAP + 1);
        send_cmd(CMD_FREE, 32'd7, '0);
        send_cmd(CMD_ALLOC, '0, '0);
        send_cmd(CMD_FILL, '0, '1);
        send_cmd(CMD_FREE, 32'd9, '0);
        send_cmd(CMD_ALLOC, '0, '0);
        send_cmd(CMD_FILL, '0, 32'd2);
        send_cmd(CMD_FILL, '0, '1);
        send_cmd(CMD_FILL, '0, '0);
        send_cmd(CMD_ALLOC, '0, '0);
        send_cmd(CMD_ALLOC, '0, '0);

        growing = 1'b1;
        target  = n_items + RANDOM_ITEMS;
        while (n_items < target)
        begin
            if ($urandom_range(0, 29) == 0)
                no_gaps = !no_gaps;
            r = $urandom_range(0, 99);
            if (refilling)
            begin
                growing = 1'b1;
                if (r < 88)
                    send_cmd(CMD_FILL, pick_word(), want_header ? pick_header() : pick_word());
                else if (r < 94)
                    send_cmd(CMD_ALLOC, pick_word(), pick_word());
                else if (r < 98)
                    send_cmd(CMD_FREE, pick_word(), pick_word());
                else
                    send_cmd(CMD_UNUSED, pick_word(), pick_word());
            end
            else
            begin
                if (held == CAP && !growing)
                    growing = 1'b0;
                else if (held == CAP && $urandom_range(0, 3) == 0)
                    growing = 1'b0;
                else if ($urandom_range(0, 59) == 0)
                    growing = !growing;
                if (r < 68)
                    send_cmd(growing ? CMD_FREE : CMD_ALLOC, pick_word(), pick_word());
                else if (r < 90)
                    send_cmd(growing ? CMD_ALLOC : CMD_FREE, pick_word(), pick_word());
                else if (r < 96)
                    send_cmd(CMD_FILL, pick_word(), pick_word());
                else
                    send_cmd(CMD_UNUSED, pick_word(), pick_word());
            end
        end
        cmd_valid <= 1'b0;

        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d commands driven, %0d reply beats checked", n_items, beats_checked);
        $display("%0d full-stack spills, %0d group reads", n_spills, n_reads);
        if (errors == 0 && outstanding == 0)
            $display("tb_grouped_free_block_stack OK");
        else
            $display("tb_grouped_free_block_stack NOT OK");
        $finish;
    end

endmodule
